[hw/rtl/pnuc_pkg.sv]
// Shared types and constants for the profile neighbour unflag check.
// Used by every module of the block; depends on nothing.
package pnuc_pkg;

    localparam int VALUE_W   = 32;
    localparam int TOL_W     = 32;
    localparam int BASE_W    = 31;
    localparam int HEIGHT_W  = 32;
    localparam int SCALE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;

    localparam logic [1:0] FLAG_PASS   = 2'd0;
    localparam logic [1:0] FLAG_FAILED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P0_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P0_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P1_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P1_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P2_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_P2_SCALE  = 3'd7;

    typedef struct packed {
        logic [BASE_W-1:0]   base_tolerance;
        logic                scale_enable;
        logic [HEIGHT_W-1:0] p0_height;
        logic [SCALE_W-1:0]  p0_scale;
        logic [HEIGHT_W-1:0] p1_height;
        logic [SCALE_W-1:0]  p1_scale;
        logic [HEIGHT_W-1:0] p2_height;
        logic [SCALE_W-1:0]  p2_scale;
    } cfg_t;

    // classified observation passed from front to back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                flag;
        logic [TOL_W-1:0]          tol;
        logic                      sel;
        logic                      pend;
    } obs_entry_t;

endpackage

[hw/rtl/pnuc_front.sv]
// Front end: accepts observations and works out each one's tolerance
// (segment pick, interpolation with a bit-serial divider, scaling). Uses pnuc_pkg.
module pnuc_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pnuc_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pnuc_pkg::VALUE_W-1:0] obs_value,
    input  logic [1:0]                        flag_class,
    input  logic [pnuc_pkg::HEIGHT_W-1:0]     vertical_coord,
    input  logic                              selected,
    input  logic                              profile_end,
    output logic                              push_valid,
    input  logic                              push_ready,
    output pnuc_pkg::obs_entry_t              push_entry
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SCL  = 6'b010000,
        ST_PUSH = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic signed [pnuc_pkg::VALUE_W-1:0] value_reg;
    logic [1:0]                          flag_reg;
    logic                                sel_reg;
    logic                                pend_reg;
    logic [pnuc_pkg::HEIGHT_W-1:0]       h_reg, ha_reg, hb_reg;
    logic [pnuc_pkg::SCALE_W-1:0]        sa_reg, sb_reg, s_reg, quo_reg, num_lo_reg;
    logic [pnuc_pkg::HEIGHT_W+pnuc_pkg::SCALE_W-1:0] prod_a_reg, prod_b_reg;
    logic [pnuc_pkg::HEIGHT_W-1:0]       rem_reg;
    logic [3:0]                          cnt_reg;
    logic [pnuc_pkg::BASE_W+pnuc_pkg::SCALE_W-1:0]   scaled_reg;

    logic                                accept_in;
    logic                                le0, le1, le2, scaling, interp, seg1;
    logic [pnuc_pkg::SCALE_W-1:0]        s_fixed;
    logic [pnuc_pkg::HEIGHT_W+pnuc_pkg::SCALE_W:0]   num;
    logic [pnuc_pkg::HEIGHT_W-1:0]       width;
    logic [pnuc_pkg::HEIGHT_W:0]         trial, trial_sub;
    logic                                ge;
    logic [pnuc_pkg::TOL_W-1:0]          tol;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_in = in_valid && in_ready;

    assign le0     = vertical_coord <= cfg.p0_height;
    assign le1     = vertical_coord <= cfg.p1_height;
    assign le2     = vertical_coord <= cfg.p2_height;
    assign scaling = selected && cfg.scale_enable;
    assign interp  = scaling && !le0 && (le1 || le2);
    assign seg1    = !le1;
    assign s_fixed = !scaling ? pnuc_pkg::SCALE_ONE : (le0 ? cfg.p0_scale : cfg.p2_scale);

    assign num       = {1'b0, prod_a_reg} + {1'b0, prod_b_reg};
    assign width     = hb_reg - ha_reg;
    assign trial     = {rem_reg, num_lo_reg[pnuc_pkg::SCALE_W-1]};
    assign ge        = trial >= {1'b0, width};
    assign trial_sub = trial - {1'b0, width};

    // saturate (base * s) >> 8 to 32 bits
    assign tol = (|scaled_reg[pnuc_pkg::BASE_W+pnuc_pkg::SCALE_W-1:pnuc_pkg::TOL_W+8])
               ? {pnuc_pkg::TOL_W{1'b1}} : scaled_reg[pnuc_pkg::TOL_W+7:8];

    assign push_valid      = (state_reg == ST_PUSH);
    assign push_entry.value = value_reg;
    assign push_entry.flag  = flag_reg;
    assign push_entry.tol   = tol;
    assign push_entry.sel   = sel_reg;
    assign push_entry.pend  = pend_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept_in) state_next = interp ? ST_MUL : ST_SCL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 4'd15) state_next = ST_SCL;
            ST_SCL:  state_next = ST_PUSH;
            ST_PUSH: if (push_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                value_reg <= obs_value;
                flag_reg  <= flag_class;
                sel_reg   <= selected;
                pend_reg  <= profile_end;
                h_reg     <= vertical_coord;
                ha_reg    <= seg1 ? cfg.p1_height : cfg.p0_height;
                hb_reg    <= seg1 ? cfg.p2_height : cfg.p1_height;
                sa_reg    <= seg1 ? cfg.p1_scale : cfg.p0_scale;
                sb_reg    <= seg1 ? cfg.p2_scale : cfg.p1_scale;
                s_reg     <= s_fixed;
            end
            ST_MUL:
            begin
                prod_a_reg <= sa_reg * (hb_reg - h_reg);
                prod_b_reg <= sb_reg * (h_reg - ha_reg);
            end
            ST_SUM:
            begin
                // interpolated scale fits 16 bits, so the high part is below width
                rem_reg    <= num[pnuc_pkg::HEIGHT_W+pnuc_pkg::SCALE_W-1:pnuc_pkg::SCALE_W];
                num_lo_reg <= num[pnuc_pkg::SCALE_W-1:0];
                cnt_reg    <= 4'd0;
            end
            ST_DIV:
            begin
                rem_reg    <= ge ? trial_sub[pnuc_pkg::HEIGHT_W-1:0]
                                 : trial[pnuc_pkg::HEIGHT_W-1:0];
                num_lo_reg <= {num_lo_reg[pnuc_pkg::SCALE_W-2:0], 1'b0};
                quo_reg    <= {quo_reg[pnuc_pkg::SCALE_W-2:0], ge};
                cnt_reg    <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    s_reg <= {quo_reg[pnuc_pkg::SCALE_W-2:0], ge};
            end
            ST_SCL:
                scaled_reg <= cfg.base_tolerance * s_reg;
            default: ;
        endcase
    end

endmodule

[hw/rtl/pnuc_queue.sv]
// Two-entry queue between front and back ends.
// Uses pnuc_pkg for the entry type and depth.
module pnuc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  pnuc_pkg::obs_entry_t push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output pnuc_pkg::obs_entry_t pop_entry
);

    pnuc_pkg::obs_entry_t          mem_reg [pnuc_pkg::QUEUE_DEPTH];
    logic [pnuc_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pnuc_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign push_ready = count_reg != pnuc_pkg::QCNT_W'(pnuc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[hw/rtl/pnuc_back.sv]
// Back end: neighbour window over held observation, decisions and output staging.
// Uses pnuc_pkg for the entry type and flag codes.
module pnuc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  pnuc_pkg::obs_entry_t pop_entry,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accept,
    output logic                 profile_last,
    output logic                 run_last
);

    logic                                held_valid_reg;
    logic signed [pnuc_pkg::VALUE_W-1:0] held_value_reg;
    logic [1:0]                          held_flag_reg;
    logic [pnuc_pkg::TOL_W-1:0]          held_tol_reg;
    logic                                held_left_ok_reg;

    logic out_valid_reg, out_acc_reg, out_plast_reg, out_last_reg;
    logic pend_valid_reg, pend_acc_reg;

    logic                        slot_free, take;
    pnuc_pkg::obs_entry_t        e;
    logic [pnuc_pkg::VALUE_W:0]  diff, abs_diff;
    logic                        right_ok, left_new, left_ok, held_fail, cur_fail;
    logic                        r0_valid, r0_acc, r0_plast, r0_last, r1_valid, r1_acc;

    assign e         = pop_entry;
    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = slot_free && !pend_valid_reg;
    assign take      = pop_valid && pop_ready;

    assign diff      = {e.value[pnuc_pkg::VALUE_W-1], e.value}
                     - {held_value_reg[pnuc_pkg::VALUE_W-1], held_value_reg};
    assign abs_diff  = diff[pnuc_pkg::VALUE_W] ? -diff : diff;
    assign right_ok  = (e.flag == pnuc_pkg::FLAG_PASS) && (abs_diff < {1'b0, held_tol_reg});
    assign left_new  = (held_flag_reg == pnuc_pkg::FLAG_PASS) && (abs_diff < {1'b0, e.tol});
    assign left_ok   = held_valid_reg ? left_new : 1'b1;
    assign held_fail = (held_flag_reg == pnuc_pkg::FLAG_FAILED) && held_left_ok_reg;
    assign cur_fail  = (e.flag == pnuc_pkg::FLAG_FAILED) && left_ok;

    always_comb
    begin
        r0_valid = 1'b0;
        r0_acc   = 1'b0;
        r0_plast = 1'b0;
        r0_last  = 1'b1;
        r1_valid = 1'b0;
        r1_acc   = 1'b0;
        if (!e.sel)
        begin
            // unselected end flushes the held observation
            r0_valid = e.pend && held_valid_reg;
            r0_acc   = held_fail;
            r0_plast = 1'b1;
        end
        else if (held_valid_reg)
        begin
            r0_valid = 1'b1;
            r0_acc   = held_fail && right_ok;
            r0_last  = !e.pend;
            r1_valid = e.pend;
            r1_acc   = cur_fail;
        end
        else
        begin
            r0_valid = e.pend;
            r0_acc   = cur_fail;
            r0_plast = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (e.pend)
                    held_valid_reg <= 1'b0;
                else if (e.sel)
                    held_valid_reg <= 1'b1;
                out_valid_reg  <= r0_valid;
                pend_valid_reg <= r1_valid;
            end
            else if (slot_free)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (e.sel && !e.pend)
            begin
                held_value_reg   <= e.value;
                held_flag_reg    <= e.flag;
                held_tol_reg     <= e.tol;
                held_left_ok_reg <= left_ok;
            end
            out_acc_reg   <= r0_acc;
            out_plast_reg <= r0_plast;
            out_last_reg  <= r0_last;
            pend_acc_reg  <= r1_acc;
        end
        else if (slot_free && pend_valid_reg)
        begin
            out_acc_reg   <= pend_acc_reg;
            out_plast_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accept       = out_acc_reg;
    assign profile_last = out_plast_reg;
    assign run_last     = out_last_reg;

    // a beat that is not the last of its run always has its follower staged
    a_first_has_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> pend_valid_reg)
        else $error("non-last beat without staged second result");

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result staged with empty output slot");

    a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !pop_ready)
        else $error("queue popped while second result waits");

    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && out_ready |=> out_valid_reg && out_last_reg && !pend_valid_reg)
        else $error("staged result not moved to output");

endmodule

[hw/rtl/profile_neighbour_unflag_check.sv]
// Top level of the profile neighbour unflag check: register file, front, queue, back.
// Depends on pnuc_pkg, pnuc_front, pnuc_queue and pnuc_back.
//
//   channel | signals                               | beat
//   in      | in_valid/in_ready + 5 field ports     | one observation
//   out     | out_valid/out_ready + 3 field ports   | one decision
//   cfg     | cfg_we, cfg_index, cfg_data           | one register write
//
// Front takes a new observation only after pushing the last: scaling and push when
// unscaled or clamped, else two multiplies, a sum, 16 divider steps, scaling, push.
// Back end takes one queued entry per cycle unless output stalls or a beat is staged.
// Reset clears control state and loads register defaults; no clearing pass.
// The two-entry queue lets the front keep working while the output is stalled.
module profile_neighbour_unflag_check
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pnuc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pnuc_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pnuc_pkg::VALUE_W-1:0]  obs_value,
    input  logic [1:0]                           flag_class,
    input  logic [pnuc_pkg::HEIGHT_W-1:0]        vertical_coord,
    input  logic                                 selected,
    input  logic                                 profile_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accept,
    output logic                                 profile_last,
    output logic                                 run_last
);

    pnuc_pkg::cfg_t       cfg_reg;
    pnuc_pkg::obs_entry_t push_entry, pop_entry;
    logic                 push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_tolerance <= 31'd65536;
            cfg_reg.scale_enable   <= 1'b0;
            cfg_reg.p0_height      <= '0;
            cfg_reg.p0_scale       <= pnuc_pkg::SCALE_ONE;
            cfg_reg.p1_height      <= '0;
            cfg_reg.p1_scale       <= pnuc_pkg::SCALE_ONE;
            cfg_reg.p2_height      <= '0;
            cfg_reg.p2_scale       <= pnuc_pkg::SCALE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pnuc_pkg::REG_BASE_TOL:  cfg_reg.base_tolerance <= cfg_data[pnuc_pkg::BASE_W-1:0];
                pnuc_pkg::REG_SCALE_EN:  cfg_reg.scale_enable   <= cfg_data[0];
                pnuc_pkg::REG_P0_HEIGHT: cfg_reg.p0_height      <= cfg_data;
                pnuc_pkg::REG_P0_SCALE:  cfg_reg.p0_scale       <= cfg_data[pnuc_pkg::SCALE_W-1:0];
                pnuc_pkg::REG_P1_HEIGHT: cfg_reg.p1_height      <= cfg_data;
                pnuc_pkg::REG_P1_SCALE:  cfg_reg.p1_scale       <= cfg_data[pnuc_pkg::SCALE_W-1:0];
                pnuc_pkg::REG_P2_HEIGHT: cfg_reg.p2_height      <= cfg_data;
                pnuc_pkg::REG_P2_SCALE:  cfg_reg.p2_scale       <= cfg_data[pnuc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    pnuc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .obs_value      (obs_value),
        .flag_class     (flag_class),
        .vertical_coord (vertical_coord),
        .selected       (selected),
        .profile_end    (profile_end),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    pnuc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pnuc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accept       (accept),
        .profile_last (profile_last),
        .run_last     (run_last)
    );

endmodule
